// File: src/parallax_cull_outline_emitter_unit_defines.svh
// Assertion macros used by the checker file of the outline emitter.
`ifndef PARALLAX_CULL_OUTLINE_EMITTER_UNIT_DEFINES_SVH
`define PARALLAX_CULL_OUTLINE_EMITTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PCOE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PCOE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pcoe_pkg.sv
// Types, constants and the vertex ROM of the outline emitter.
package pcoe_pkg;

    // Field widths
    localparam int WORLD_W  = 24;
    localparam int DEPTH_W  = 9;
    localparam int SCALE_W  = 10;
    localparam int SHAPE_W  = 2;
    localparam int RADIUS_W = 23;
    localparam int POS_W    = 25;
    localparam int EDGE_W   = 3;
    localparam int VCNT_W   = 4;
    localparam int VERT_W   = 11;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_RADIUS = 2'd2;

    // Parallax arithmetic: shift = floor((cam * k + 2560) / 5120), k = 4864 - 15 * depth
    localparam logic signed [13:0] K_BASE    = 14'sd4864;
    localparam logic signed [37:0] CAM_ROUND = 38'sd2560;
    // Divide by five: bias to non-negative, multiply by floor(2^30 / 5), correct once
    localparam logic [29:0] DIV5_BIAS  = 30'd671088640;
    localparam logic [27:0] DIV5_MAGIC = 28'd214748364;
    localparam logic [27:0] DIV5_UNBIAS = 28'd134217728;

    // Vertex ROM, 1/256 units
    localparam int ROM_SHAPES = 4;
    localparam int ROM_SLOTS  = 8;

    localparam logic signed [VERT_W-1:0] ROM_X [ROM_SHAPES][ROM_SLOTS] = '{
        '{-11'sd512, -11'sd128,  11'sd307,  11'sd512,  11'sd256, -11'sd205, -11'sd512,  11'sd0},
        '{-11'sd256,  11'sd205,  11'sd461,  11'sd307, -11'sd77,  -11'sd384, -11'sd461,  11'sd0},
        '{ 11'sd0,    11'sd256,  11'sd333,  11'sd0,   -11'sd333, -11'sd256,  11'sd0,    11'sd0},
        '{-11'sd563, -11'sd256,  11'sd256,  11'sd563,  11'sd512,  11'sd128, -11'sd307, -11'sd563}
    };

    localparam logic signed [VERT_W-1:0] ROM_Y [ROM_SHAPES][ROM_SLOTS] = '{
        '{-11'sd205, -11'sd358, -11'sd256,  11'sd51,   11'sd282,  11'sd333,  11'sd128,  11'sd0},
        '{-11'sd512, -11'sd384, -11'sd77,   11'sd358,  11'sd461,  11'sd154, -11'sd205,  11'sd0},
        '{-11'sd384, -11'sd128,  11'sd205,  11'sd384,  11'sd205, -11'sd128,  11'sd0,    11'sd0},
        '{-11'sd128, -11'sd384, -11'sd384, -11'sd77,   11'sd205,  11'sd384,  11'sd307,  11'sd77}
    };

    localparam logic [VCNT_W-1:0] ROM_LEN [ROM_SHAPES] = '{4'd7, 4'd7, 4'd6, 4'd8};

    // Configuration register set
    typedef struct packed {
        logic signed [WORLD_W-1:0]  camera_x;
        logic signed [WORLD_W-1:0]  camera_y;
        logic        [RADIUS_W-1:0] view_radius;
    } cfg_t;

    // One kept object, handed from the front end to the edge sequencer
    typedef struct packed {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic        [SCALE_W-1:0] scale;
        logic        [SHAPE_W-1:0] shape;
        logic        [VCNT_W-1:0]  vcount;
    } job_t;

endpackage

// File: src/pcoe_if.sv
// Valid/ready channels: object words in, segment words out.
interface pcoe_obj_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pcoe_pkg::WORLD_W-1:0]  world_x;
    logic signed [pcoe_pkg::WORLD_W-1:0]  world_y;
    logic        [pcoe_pkg::DEPTH_W-1:0]  depth;
    logic        [pcoe_pkg::SCALE_W-1:0]  shape_scale;
    logic        [pcoe_pkg::SHAPE_W-1:0]  shape_index;

    modport source (output valid, world_x, world_y, depth, shape_scale, shape_index,
                    input ready);
    modport sink   (input valid, world_x, world_y, depth, shape_scale, shape_index,
                    output ready);
endinterface

interface pcoe_seg_if #(parameter int COORD_BITS = 24);
    logic                                valid;
    logic                                ready;
    logic signed [COORD_BITS-1:0]        start_x;
    logic signed [COORD_BITS-1:0]        start_y;
    logic signed [COORD_BITS-1:0]        end_x;
    logic signed [COORD_BITS-1:0]        end_y;
    logic        [pcoe_pkg::EDGE_W-1:0]  edge_number;
    logic                                last_edge;

    modport source (output valid, start_x, start_y, end_x, end_y, edge_number, last_edge,
                    input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, edge_number, last_edge,
                    output ready);
endinterface

// File: src/parallax_cull_outline_emitter_unit.sv
// Top level of the parallax cull outline emitter.
// Each object word is placed at world + camera * (0.95 - 0.75 * depth / 256), culled when it
// lies outside view_radius of the camera or its shape index is not below SHAPE_COUNT, and
// otherwise turned into one segment word per polygon edge, the last one flagged. The front
// end works on one object at a time through multiply, divide-by-5120, placement, squaring
// and compare steps; the objects port is ready only between objects. Kept objects pass
// through a two-entry queue to the edge sequencer, which sends at most one segment word
// per cycle from its output register. Configuration is written through cfg_write /
// cfg_index / cfg_data; the user must write it only while no object is in flight, and the
// block itself does not enforce this.
module parallax_cull_outline_emitter_unit #(
    parameter int SHAPE_COUNT  = 4,
    parameter int MAX_VERTICES = 8,
    parameter int COORD_BITS   = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [pcoe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcoe_pkg::CFG_W-1:0]        cfg_data,
    pcoe_obj_if.sink                          objects,
    pcoe_seg_if.source                        segments
);

    pcoe_pkg::cfg_t cfg_reg;
    pcoe_pkg::job_t push_job, head;
    logic           push, full, pop, empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pcoe_pkg::REG_CAMERA_X:    cfg_reg.camera_x    <= cfg_data;
                pcoe_pkg::REG_CAMERA_Y:    cfg_reg.camera_y    <= cfg_data;
                pcoe_pkg::REG_VIEW_RADIUS:
                    cfg_reg.view_radius <= cfg_data[pcoe_pkg::RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    pcoe_front #(
        .SHAPE_COUNT  (SHAPE_COUNT),
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .objects  (objects),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    pcoe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    pcoe_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .segments (segments)
    );

endmodule

// File: src/pcoe_front.sv
// Front end: takes object words, places them with parallax and culls by view radius.
module pcoe_front #(
    parameter int SHAPE_COUNT  = 4,
    parameter int MAX_VERTICES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pcoe_pkg::cfg_t      cfg,
    pcoe_obj_if.sink            objects,
    output logic                push,
    output pcoe_pkg::job_t      push_job,
    input  logic                full
);

    localparam int NMAX = (MAX_VERTICES < pcoe_pkg::ROM_SLOTS) ? MAX_VERTICES
                                                               : pcoe_pkg::ROM_SLOTS;

    typedef enum logic [2:0] {F_IDLE, F_MUL, F_DIV, F_POS, F_SQR, F_DEC} state_t;

    state_t state_reg;

    logic signed [pcoe_pkg::WORLD_W-1:0] wx_reg, wy_reg;
    logic signed [13:0]                  k_reg;
    logic [pcoe_pkg::SCALE_W-1:0]        scale_reg;
    logic [pcoe_pkg::SHAPE_W-1:0]        shape_reg;
    logic signed [37:0]                  ax_reg, ay_reg;
    logic [29:0]                         ux_reg, uy_reg;
    logic [57:0]                         mx_reg, my_reg;
    logic signed [pcoe_pkg::POS_W-1:0]   px_reg, py_reg;
    logic [50:0]                         dxx_reg, dyy_reg;
    logic [45:0]                         rr_reg;

    logic               accept;
    logic signed [13:0] k_next;
    logic [12:0]        depth15;
    logic signed [37:0] ax_next, ay_next;
    logic signed [27:0] ash_x, ash_y;
    logic [29:0]        ux_next, uy_next;
    logic [27:0]        qx0, qy0, qx, qy, sx, sy;
    logic [29:0]        rx, ry;
    logic signed [pcoe_pkg::POS_W-1:0] px_next, py_next;
    logic signed [25:0] dx, dy;
    logic signed [51:0] sqx, sqy;
    logic [51:0]        dist_sq;
    logic               visible;
    logic               shape_ok;
    logic [pcoe_pkg::VCNT_W-1:0] rom_n;

    assign objects.ready = (state_reg == F_IDLE);
    assign accept        = objects.valid && objects.ready;

    // Parallax factor numerator, 15*depth as 16*depth - depth
    assign depth15 = {objects.depth, 4'b0} - {4'b0, objects.depth};
    assign k_next  = pcoe_pkg::K_BASE - $signed({1'b0, depth15});

    // Camera times factor, rounding offset added
    assign ax_next = cfg.camera_x * k_reg + pcoe_pkg::CAM_ROUND;
    assign ay_next = cfg.camera_y * k_reg + pcoe_pkg::CAM_ROUND;

    // Drop the low ten bits, bias for the divide by five
    assign ash_x   = ax_reg[37:10];
    assign ash_y   = ay_reg[37:10];
    assign ux_next = 30'(ash_x) + pcoe_pkg::DIV5_BIAS;
    assign uy_next = 30'(ash_y) + pcoe_pkg::DIV5_BIAS;

    // Quotient estimate, one correction step, remove the bias
    always_comb
    begin
        qx0 = mx_reg[57:30];
        qy0 = my_reg[57:30];
        rx  = ux_reg - ({qx0, 2'b0} + {2'b0, qx0});
        ry  = uy_reg - ({qy0, 2'b0} + {2'b0, qy0});
        qx  = qx0 + 28'(rx >= 30'd5);
        qy  = qy0 + 28'(ry >= 30'd5);
        sx  = qx - pcoe_pkg::DIV5_UNBIAS;
        sy  = qy - pcoe_pkg::DIV5_UNBIAS;
        px_next = 25'(wx_reg) + 25'($signed(sx));
        py_next = 25'(wy_reg) + 25'($signed(sy));
    end

    // Distance to camera, squared
    assign dx  = 26'(px_reg) - 26'(cfg.camera_x);
    assign dy  = 26'(py_reg) - 26'(cfg.camera_y);
    assign sqx = dx * dx;
    assign sqy = dy * dy;

    // Cull decision and edge count
    assign dist_sq  = 52'(dxx_reg) + 52'(dyy_reg);
    assign visible  = (dist_sq <= 52'(rr_reg));
    assign shape_ok = (int'(shape_reg) < SHAPE_COUNT);
    assign rom_n    = (pcoe_pkg::ROM_LEN[shape_reg] > 4'(NMAX)) ? 4'(NMAX)
                                                                : pcoe_pkg::ROM_LEN[shape_reg];

    assign push            = (state_reg == F_DEC) && visible && shape_ok && !full;
    assign push_job.pos_x  = px_reg;
    assign push_job.pos_y  = py_reg;
    assign push_job.scale  = scale_reg;
    assign push_job.shape  = shape_reg;
    assign push_job.vcount = rom_n;

    // Sequence one object through the arithmetic steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                        state_reg <= F_MUL;
                end
                F_MUL: state_reg <= F_DIV;
                F_DIV: state_reg <= F_POS;
                F_POS: state_reg <= F_SQR;
                F_SQR: state_reg <= F_DEC;
                F_DEC:
                begin
                    if (!visible || !shape_ok || !full)
                        state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    // Working registers of the object in flight
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wx_reg    <= objects.world_x;
            wy_reg    <= objects.world_y;
            k_reg     <= k_next;
            scale_reg <= objects.shape_scale;
            shape_reg <= objects.shape_index;
        end
        if (state_reg == F_MUL)
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
        end
        if (state_reg == F_DIV)
        begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            mx_reg <= ux_next * pcoe_pkg::DIV5_MAGIC;
            my_reg <= uy_next * pcoe_pkg::DIV5_MAGIC;
        end
        if (state_reg == F_POS)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (state_reg == F_SQR)
        begin
            dxx_reg <= sqx[50:0];
            dyy_reg <= sqy[50:0];
            rr_reg  <= cfg.view_radius * cfg.view_radius;
        end
    end

endmodule

// File: src/pcoe_queue.sv
// Two-entry queue of kept objects between front end and edge sequencer.
module pcoe_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pcoe_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output pcoe_pkg::job_t  head,
    output logic            empty
);

    pcoe_pkg::job_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: src/pcoe_back.sv
// Edge sequencer: walks the head polygon, at most one segment word per cycle.
module pcoe_back #(
    parameter int COORD_BITS = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  pcoe_pkg::job_t  head,
    input  logic            empty,
    output logic            pop,
    pcoe_seg_if.source      segments
);

    localparam int MUL_W = 2 * pcoe_pkg::VERT_W;
    localparam int EW    = (COORD_BITS > pcoe_pkg::POS_W + 1) ? COORD_BITS
                                                              : pcoe_pkg::POS_W + 1;
    localparam logic [EW-1:0] SAT_HI = {{(EW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic [EW-1:0] SAT_LO = {{(EW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    logic [pcoe_pkg::VCNT_W-1:0] vcnt_reg;
    logic                        out_valid_reg;
    logic [COORD_BITS-1:0]       prev_x_reg, prev_y_reg;
    logic [COORD_BITS-1:0]       start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [pcoe_pkg::EDGE_W-1:0] edge_reg;
    logic                        last_reg;

    logic [2:0]                         vslot;
    logic signed [pcoe_pkg::VERT_W-1:0] vx, vy;
    logic signed [MUL_W-1:0]            mx, my, ox, oy;
    logic [EW-1:0]                      sum_x, sum_y;
    logic [COORD_BITS-1:0]              cur_x, cur_y;
    logic                               step, emit, closing;

    function automatic logic [COORD_BITS-1:0] sat_coord(input logic [EW-1:0] v);
        if ($signed(v) > $signed(SAT_HI))
            return SAT_HI[COORD_BITS-1:0];
        if ($signed(v) < $signed(SAT_LO))
            return SAT_LO[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    // Current vertex: the walk ends back on vertex zero
    assign closing = (vcnt_reg == head.vcount);
    assign vslot   = closing ? 3'd0 : vcnt_reg[2:0];
    assign vx      = pcoe_pkg::ROM_X[head.shape][vslot];
    assign vy      = pcoe_pkg::ROM_Y[head.shape][vslot];

    // Scale, round half up, offset by position, saturate
    always_comb
    begin
        mx    = vx * $signed({1'b0, head.scale});
        my    = vy * $signed({1'b0, head.scale});
        ox    = (mx + MUL_W'(128)) >>> 8;
        oy    = (my + MUL_W'(128)) >>> 8;
        sum_x = {{(EW-pcoe_pkg::POS_W){head.pos_x[pcoe_pkg::POS_W-1]}}, head.pos_x}
              + {{(EW-MUL_W){ox[MUL_W-1]}}, ox};
        sum_y = {{(EW-pcoe_pkg::POS_W){head.pos_y[pcoe_pkg::POS_W-1]}}, head.pos_y}
              + {{(EW-MUL_W){oy[MUL_W-1]}}, oy};
        cur_x = sat_coord(sum_x);
        cur_y = sat_coord(sum_y);
    end

    // Advance when the output register is free or being drained
    assign emit = (vcnt_reg != '0);
    assign step = !empty && (!emit || !out_valid_reg || segments.ready);
    assign pop  = step && closing;

    // Vertex counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
                vcnt_reg <= closing ? '0 : vcnt_reg + 4'd1;
            if (step && emit)
                out_valid_reg <= 1'b1;
            else if (segments.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold previous vertex, load segment word
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
            if (emit)
            begin
                start_x_reg <= prev_x_reg;
                start_y_reg <= prev_y_reg;
                end_x_reg   <= cur_x;
                end_y_reg   <= cur_y;
                edge_reg    <= 3'(vcnt_reg - 4'd1);
                last_reg    <= closing;
            end
        end
    end

    assign segments.valid       = out_valid_reg;
    assign segments.start_x     = start_x_reg;
    assign segments.start_y     = start_y_reg;
    assign segments.end_x       = end_x_reg;
    assign segments.end_y       = end_y_reg;
    assign segments.edge_number = edge_reg;
    assign segments.last_edge   = last_reg;

endmodule

// File: src/pcoe_checker.sv
// Port-level checks of the outline emitter, bound to its top level.
`include "parallax_cull_outline_emitter_unit_defines.svh"

module pcoe_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [COORD_BITS-1:0]       start_x,
    input logic [COORD_BITS-1:0]       end_y,
    input logic [pcoe_pkg::EDGE_W-1:0] edge_number,
    input logic                        last_edge
);

    logic [pcoe_pkg::EDGE_W-1:0]            exp_edge_reg;
    logic [2*COORD_BITS+pcoe_pkg::EDGE_W:0] held_word;
    logic                                   stalled;

    assign held_word = {start_x, end_y, edge_number, last_edge};
    assign stalled   = out_valid && !out_ready;

    // Track the edge number the next segment word should carry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_edge_reg <= '0;
        else if (out_valid && out_ready)
            exp_edge_reg <= last_edge ? '0 : edge_number + 3'd1;
    end

    `PCOE_ASSERT_NOW(a_edge_order, out_valid, edge_number == exp_edge_reg, "edge out of order")
    `PCOE_ASSERT_NOW(a_last_min, out_valid && last_edge, edge_number >= 3'd2, "closed too early")
    `PCOE_ASSERT_NEXT(a_front_busy, in_valid && in_ready, !in_ready, "front not busy")
    `PCOE_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(held_word), "word not held")

endmodule

bind parallax_cull_outline_emitter_unit pcoe_checker #(
    .COORD_BITS (COORD_BITS)
) u_pcoe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (objects.valid),
    .in_ready    (objects.ready),
    .out_valid   (segments.valid),
    .out_ready   (segments.ready),
    .start_x     (segments.start_x),
    .end_y       (segments.end_y),
    .edge_number (segments.edge_number),
    .last_edge   (segments.last_edge)
);

// File: tb/sv/tb_parallax_cull_outline_emitter_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the parallax cull outline emitter: object words in, segment words out.
module tb_parallax_cull_outline_emitter_unit;

    localparam int     COORD_BITS    = 24;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     STALL_LIMIT   = 2000;
    localparam int     RANDOM_PHASES = 6;
    localparam int     PHASE_WORDS   = 60;
    localparam longint COORD_MAX     = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN     = -COORD_MAX - 1;
    localparam longint RADIUS_MAX    = (longint'(1) <<< pcoe_pkg::RADIUS_W) - 1;

    // Polygon outlines, 1/256 units, in edge order
    localparam int OUTLINE_X [0:3][0:7] = '{
        '{-512, -128,  307,  512,  256, -205, -512,    0},
        '{-256,  205,  461,  307,  -77, -384, -461,    0},
        '{   0,  256,  333,    0, -333, -256,    0,    0},
        '{-563, -256,  256,  563,  512,  128, -307, -563}
    };
    localparam int OUTLINE_Y [0:3][0:7] = '{
        '{-205, -358, -256,   51,  282,  333,  128,    0},
        '{-512, -384,  -77,  358,  461,  154, -205,    0},
        '{-384, -128,  205,  384,  205, -128,    0,    0},
        '{-128, -384, -384,  -77,  205,  384,  307,   77}
    };
    localparam int OUTLINE_LEN [0:3] = '{7, 7, 6, 8};

    typedef struct {
        logic signed [pcoe_pkg::WORLD_W-1:0] world_x;
        logic signed [pcoe_pkg::WORLD_W-1:0] world_y;
        logic        [pcoe_pkg::DEPTH_W-1:0] depth;
        logic        [pcoe_pkg::SCALE_W-1:0] shape_scale;
        logic        [pcoe_pkg::SHAPE_W-1:0] shape_index;
    } object_word_t;

    typedef struct {
        logic signed [COORD_BITS-1:0]       start_x;
        logic signed [COORD_BITS-1:0]       start_y;
        logic signed [COORD_BITS-1:0]       end_x;
        logic signed [COORD_BITS-1:0]       end_y;
        logic        [pcoe_pkg::EDGE_W-1:0] edge_number;
        logic                               last_edge;
    } segment_word_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_write;
    logic [pcoe_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pcoe_pkg::CFG_W-1:0]     cfg_data;

    pcoe_obj_if                             obj_ch ();
    pcoe_seg_if #(.COORD_BITS(COORD_BITS))  seg_ch ();

    object_word_t  pending_objects [$];
    segment_word_t segment_expect [$];
    object_word_t  shown_object;

    longint cur_camera_x;
    longint cur_camera_y;
    longint cur_radius;
    int     stall_pct;
    int     fail_count;
    int     src_gap;
    int     snk_gap;
    int     quiet_cycles;

    parallax_cull_outline_emitter_unit #(
        .SHAPE_COUNT  (4),
        .MAX_VERTICES (8),
        .COORD_BITS   (COORD_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .objects   (obj_ch.sink),
        .segments  (seg_ch.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint floor_div(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // Camera shift for a depth: camera * (0.95 - 0.75 * depth / 256), rounded half up
    function automatic longint parallax_shift(longint cam, longint depth);
        return floor_div(cam * (4864 - 15 * depth) + 2560, 5120);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v[COORD_BITS-1:0];
    endfunction

    // Append one object word to the pending list
    function automatic void add_object(object_word_t obj);
        pending_objects.insert(pending_objects.size(), obj);
    endfunction

    // Place the object, cull it, and queue one segment word per polygon edge
    function automatic void predict_outline(object_word_t obj);
        longint        px;
        longint        py;
        longint        dx;
        longint        dy;
        longint        scale;
        int            shape;
        int            n;
        int            i;
        int            j;
        segment_word_t seg;
        px = longint'(obj.world_x) + parallax_shift(cur_camera_x, longint'(obj.depth));
        py = longint'(obj.world_y) + parallax_shift(cur_camera_y, longint'(obj.depth));
        dx = px - cur_camera_x;
        dy = py - cur_camera_y;
        if (dx * dx + dy * dy > cur_radius * cur_radius)
            return;
        shape = int'(obj.shape_index);
        n     = OUTLINE_LEN[shape];
        scale = longint'(obj.shape_scale);
        for (i = 0; i < n; i++)
        begin
            j = (i + 1 == n) ? 0 : i + 1;
            seg.start_x = clamp_coord(px + floor_div(OUTLINE_X[shape][i] * scale + 128, 256));
            seg.start_y = clamp_coord(py + floor_div(OUTLINE_Y[shape][i] * scale + 128, 256));
            seg.end_x   = clamp_coord(px + floor_div(OUTLINE_X[shape][j] * scale + 128, 256));
            seg.end_y   = clamp_coord(py + floor_div(OUTLINE_Y[shape][j] * scale + 128, 256));
            seg.edge_number = 3'(i);
            seg.last_edge   = (i + 1 == n);
            segment_expect.insert(segment_expect.size(), seg);
        end
    endfunction

    function automatic object_word_t make_object(longint wx, longint wy, longint depth,
                                                 longint scale, longint shape);
        object_word_t obj;
        obj.world_x     = wx[pcoe_pkg::WORLD_W-1:0];
        obj.world_y     = wy[pcoe_pkg::WORLD_W-1:0];
        obj.depth       = depth[pcoe_pkg::DEPTH_W-1:0];
        obj.shape_scale = scale[pcoe_pkg::SCALE_W-1:0];
        obj.shape_index = shape[pcoe_pkg::SHAPE_W-1:0];
        return obj;
    endfunction

    function automatic longint jitter(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    // Object that lands within span of the camera on each axis
    function automatic object_word_t placed_object(longint depth, longint scale, longint shape,
                                                   longint span);
        longint wx;
        longint wy;
        wx = cur_camera_x - parallax_shift(cur_camera_x, depth) + jitter(span);
        wy = cur_camera_y - parallax_shift(cur_camera_y, depth) + jitter(span);
        return make_object(wx, wy, depth, scale, shape);
    endfunction

    function automatic object_word_t random_placed_object();
        longint depth;
        longint scale;
        depth = ($urandom_range(0, 9) == 0) ? $urandom_range(257, 511)
                                            : $urandom_range(0, 256);
        scale = ($urandom_range(0, 9) == 0) ? $urandom_range(513, 1023)
                                            : $urandom_range(0, 512);
        return placed_object(depth, scale, $urandom_range(0, 3), cur_radius * 8 / 10);
    endfunction

    function automatic longint random_coord();
        logic [31:0] bits;
        bits = $urandom();
        return longint'($signed(bits[pcoe_pkg::WORLD_W-1:0]));
    endfunction

    function automatic object_word_t noise_object();
        return make_object(random_coord(), random_coord(), $urandom_range(0, 511),
                           $urandom_range(0, 1023), $urandom_range(0, 3));
    endfunction

    task automatic write_reg(input logic [pcoe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pcoe_pkg::CFG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            pcoe_pkg::REG_CAMERA_X:    cur_camera_x = longint'($signed(data));
            pcoe_pkg::REG_CAMERA_Y:    cur_camera_y = longint'($signed(data));
            pcoe_pkg::REG_VIEW_RADIUS:
                cur_radius = longint'(data[pcoe_pkg::RADIUS_W-1:0]);
            default:                   ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_view(input longint cx, input longint cy, input longint r);
        write_reg(pcoe_pkg::REG_CAMERA_X, cx[pcoe_pkg::CFG_W-1:0]);
        write_reg(pcoe_pkg::REG_CAMERA_Y, cy[pcoe_pkg::CFG_W-1:0]);
        write_reg(pcoe_pkg::REG_VIEW_RADIUS, r[pcoe_pkg::CFG_W-1:0]);
    endtask

    // Hold until every word is taken and every segment is back, then let the pipe settle
    task automatic drain();
        while (pending_objects.size() != 0 || obj_ch.valid || segment_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Object driver: predict each word taken, then present the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_ch.valid       <= 1'b0;
            obj_ch.world_x     <= '0;
            obj_ch.world_y     <= '0;
            obj_ch.depth       <= '0;
            obj_ch.shape_scale <= '0;
            obj_ch.shape_index <= '0;
            src_gap = 0;
        end
        else
        begin
            if (obj_ch.valid && obj_ch.ready)
                predict_outline(shown_object);
            if (!obj_ch.valid || obj_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    obj_ch.valid <= 1'b0;
                end
                else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
                begin
                    src_gap = $urandom_range(1, 16) - 1;
                    obj_ch.valid <= 1'b0;
                end
                else if (pending_objects.size() != 0)
                begin
                    shown_object = pending_objects.pop_front();
                    obj_ch.world_x     <= shown_object.world_x;
                    obj_ch.world_y     <= shown_object.world_y;
                    obj_ch.depth       <= shown_object.depth;
                    obj_ch.shape_scale <= shown_object.shape_scale;
                    obj_ch.shape_index <= shown_object.shape_index;
                    obj_ch.valid       <= 1'b1;
                end
                else
                    obj_ch.valid <= 1'b0;
            end
        end
    end

    // Segment monitor: compare each word taken with the oldest expectation, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        segment_word_t want;
        if (!rst_n)
        begin
            seg_ch.ready <= 1'b0;
            snk_gap = 0;
        end
        else
        begin
            if (seg_ch.valid && seg_ch.ready)
            begin
                if (segment_expect.size() == 0)
                begin
                    $error("segment word with none expected, edge_number %0d",
                           seg_ch.edge_number);
                    fail_count++;
                end
                else
                begin
                    want = segment_expect.pop_front();
                    check_field("start_x", want.start_x, seg_ch.start_x);
                    check_field("start_y", want.start_y, seg_ch.start_y);
                    check_field("end_x", want.end_x, seg_ch.end_x);
                    check_field("end_y", want.end_y, seg_ch.end_y);
                    check_field("edge_number", want.edge_number, seg_ch.edge_number);
                    check_field("last_edge", want.last_edge, seg_ch.last_edge);
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                seg_ch.ready <= 1'b0;
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                snk_gap = $urandom_range(1, 16) - 1;
                seg_ch.ready <= 1'b0;
            end
            else
                seg_ch.ready <= 1'b1;
        end
    end

    // Watchdog: end the run when no word moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((obj_ch.valid && obj_ch.ready) || (seg_ch.valid && seg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        int phase_no;
        int n;
        fail_count   = 0;
        quiet_cycles = 0;
        stall_pct    = 25;
        cur_camera_x = 0;
        cur_camera_y = 0;
        cur_radius   = 0;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= pcoe_pkg::REG_CAMERA_X;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset view: only objects placed exactly on the camera survive a zero radius
        for (n = 0; n < 4; n++)
            add_object(placed_object(0, 256, n, 0));
        add_object(placed_object(256, 512, 3, 0));
        add_object(placed_object(511, 1023, 0, 0));
        add_object(placed_object(128, 0, 1, 0));
        add_object(make_object(1, 0, 0, 256, 2));
        add_object(make_object(COORD_MAX, COORD_MIN, 0, 512, 0));
        add_object(make_object(COORD_MIN, COORD_MAX, 256, 1023, 3));
        drain();

        // Camera at the top corner, widest radius: endpoints clip high
        set_view(COORD_MAX, COORD_MAX, RADIUS_MAX);
        add_object(placed_object(0, 1023, 3, 0));
        add_object(placed_object(256, 1023, 0, 0));
        add_object(placed_object(511, 1023, 2, 0));
        add_object(make_object(COORD_MAX, COORD_MAX, 0, 1023, 3));
        drain();

        // Camera at the bottom corner: endpoints clip low
        set_view(COORD_MIN, COORD_MIN, RADIUS_MAX);
        add_object(placed_object(0, 1023, 3, 0));
        add_object(placed_object(256, 1023, 1, 0));
        add_object(placed_object(511, 1023, 2, 0));
        add_object(make_object(COORD_MIN, COORD_MIN, 256, 1023, 0));
        drain();

        // Random phases, each with its own view and idling; phase 3 and the last run without idling
        for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++)
        begin
            case (phase_no)
                0:
                begin
                    set_view(random_coord(), random_coord(), $urandom_range(0, 4095));
                    stall_pct = 20;
                end
                1:
                begin
                    set_view(random_coord(), random_coord(), $urandom_range(0, RADIUS_MAX));
                    stall_pct = 40;
                end
                2:
                begin
                    set_view(COORD_MAX, COORD_MIN, $urandom_range(0, 1 << 20));
                    stall_pct = 10;
                end
                3:
                begin
                    set_view(random_coord(), random_coord(), RADIUS_MAX);
                    stall_pct = 0;
                end
                4:
                begin
                    set_view(0, 0, $urandom_range(0, RADIUS_MAX));
                    stall_pct = 30;
                end
                default:
                begin
                    set_view(random_coord(), random_coord(), 65535);
                    stall_pct = 0;
                end
            endcase
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(0, 99) < 15)
                    add_object(noise_object());
                else
                    add_object(random_placed_object());
            end
            drain();
        end

        if (fail_count == 0 && segment_expect.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: parallax_cull_outline_emitter_unit.f
+incdir+src
src/pcoe_pkg.sv
src/pcoe_if.sv
src/pcoe_front.sv
src/pcoe_queue.sv
src/pcoe_back.sv
src/parallax_cull_outline_emitter_unit.sv
src/pcoe_checker.sv
tb/sv/tb_parallax_cull_outline_emitter_unit.sv
